// ----- src/bfe_pkg.sv -----
// Shared types, constants and functions for the braille frame encoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bfe_pkg;

	// Default cap on the lead-in and trailer lengths
	localparam int SEQ_MAX_DEF = 4;

	// Escape value; a mapped cell equal to it goes out twice
	localparam logic [7:0] ESC_BYTE = 8'h1b;

	// Register indexes of the configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_LEN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_BYTES  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRAIL_LEN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRAIL_BYTES = 3'd3;

	// Target bit of each dot bit
	localparam logic [2:0] DOT_MAP [8] = '{3'd0, 3'd7, 3'd1, 3'd6, 3'd2, 3'd5, 3'd3, 3'd4};

	// Configuration register contents
	typedef struct packed {
		logic [2:0]  lead_length;
		logic [31:0] lead_bytes;
		logic [2:0]  trail_length;
		logic [31:0] trail_bytes;
	} cfg_t;

	// One emitted byte from the sequencer, plus its hold status
	typedef struct packed {
		logic       busy;
		logic       emit;
		logic       last;
		logic [7:0] data;
	} seq_out_t;

	// Permute the eight dots into link order
	function automatic logic [7:0] map_cell(input logic [7:0] dots);
		logic [7:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (dots[i]) begin
				r[DOT_MAP[i]] = 1'b1;
			end
		end
		return r;
	endfunction

	// Pick byte k of a sequence register; bytes past the fourth are zero
	function automatic logic [7:0] seq_byte(input logic [31:0] bytes, input logic [2:0] k);
		logic [7:0] b;
		case (k)
			3'd0: b = bytes[7:0];
			3'd1: b = bytes[15:8];
			3'd2: b = bytes[23:16];
			3'd3: b = bytes[31:24];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- src/bfe_cfg_regs.sv -----
// Configuration register file of the braille frame encoder.
// Depends on bfe_pkg for register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module bfe_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [bfe_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [31:0]                     wr_data,
	output bfe_pkg::cfg_t                   cfg
);
	import bfe_pkg::*;

	cfg_t cfg_q;

	// Write one register per beat; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_LEAD_LEN:    cfg_q.lead_length  <= wr_data[2:0];
				REG_LEAD_BYTES:  cfg_q.lead_bytes   <= wr_data;
				REG_TRAIL_LEN:   cfg_q.trail_length <= wr_data[2:0];
				REG_TRAIL_BYTES: cfg_q.trail_bytes  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/bfe_seq.sv -----
// Input stage and byte sequencer: holds one cell and steps through its
// lead-in, cell, escape copy and trailer bytes. Depends on bfe_pkg.
`timescale 1ns / 1ps

module bfe_seq #(
	parameter int SEQ_MAX = bfe_pkg::SEQ_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bfe_pkg::cfg_t      cfg,
	input  logic               in_valid,
	input  logic [7:0]         in_cell,
	input  logic               in_first,
	input  logic               in_last,
	output logic               in_take,
	input  logic               out_free,
	output bfe_pkg::seq_out_t  seq_out
);
	import bfe_pkg::*;

	localparam int CNT_W = (SEQ_MAX < 3) ? 3 : $clog2(2 * SEQ_MAX + 2);
	localparam logic [CNT_W-1:0] LEN_CAP = CNT_W'(SEQ_MAX);

	logic             valid_s1;
	logic [7:0]       mapped_s1;
	logic             first_s1;
	logic             last_s1;
	logic [CNT_W-1:0] idx_q;

	logic [CNT_W-1:0] lead_cap;
	logic [CNT_W-1:0] trail_cap;
	logic [CNT_W-1:0] lead_n;
	logic [CNT_W-1:0] trail_n;
	logic [CNT_W-1:0] esc_n;
	logic [CNT_W-1:0] end_idx;
	logic [CNT_W-1:0] trail_k;
	logic             is_esc;
	logic             at_end;
	logic             advance;
	logic [7:0]       byte_sel;

	// Clamp the configured lengths
	assign lead_cap  = (CNT_W'(cfg.lead_length) > LEN_CAP) ? LEN_CAP : CNT_W'(cfg.lead_length);
	assign trail_cap = (CNT_W'(cfg.trail_length) > LEN_CAP) ? LEN_CAP : CNT_W'(cfg.trail_length);

	// Size of the run for the held cell
	assign is_esc  = (mapped_s1 == ESC_BYTE);
	assign lead_n  = first_s1 ? lead_cap : '0;
	assign trail_n = last_s1 ? trail_cap : '0;
	assign esc_n   = CNT_W'(is_esc);
	assign end_idx = lead_n + esc_n + trail_n;
	assign trail_k = idx_q - lead_n - esc_n - CNT_W'(1);
	assign at_end  = (idx_q == end_idx);

	// Select the byte at the current step
	always_comb begin
		if (idx_q < lead_n) begin
			byte_sel = seq_byte(cfg.lead_bytes, idx_q[2:0]);
		end else if (idx_q <= lead_n + esc_n) begin
			byte_sel = mapped_s1;
		end else begin
			byte_sel = seq_byte(cfg.trail_bytes, trail_k[2:0]);
		end
	end

	assign advance = valid_s1 && out_free;
	assign in_take = !valid_s1 || (advance && at_end);

	// Load a new cell when the held one is done; otherwise step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (in_take) begin
			valid_s1 <= in_valid;
			idx_q    <= '0;
		end else if (advance) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	// Payload of the held cell
	always_ff @(posedge clk) begin
		if (in_take && in_valid) begin
			mapped_s1 <= map_cell(in_cell);
			first_s1  <= in_first;
			last_s1   <= in_last;
		end
	end

	assign seq_out.busy = valid_s1;
	assign seq_out.emit = advance;
	assign seq_out.last = at_end;
	assign seq_out.data = byte_sel;

endmodule

// ----- src/braille_frame_encoder_unit.sv -----
// Braille frame encoder: config registers, cell input stage, sequencer and output register.
// Depends on bfe_pkg, bfe_cfg_regs and bfe_seq.
//
// Usage:
//   Cell channel (cell_valid / cell_stall): one braille cell per beat with
//   first_cell / last_cell frame marks. Byte channel (byte_valid /
//   byte_stall): one link byte per beat; run_end marks the final byte of
//   a cell's run (lead-in, mapped cell, escape copy, trailer).
//   Config channel (cfg_valid / cfg_ready): always ready; cfg_index picks
//   lead_length, lead_bytes, trail_length or trail_bytes. Write only while
//   the block is idle.
// Timing:
//   A cell's first byte passes the sequencer's hold register and the output
//   register before it reaches the byte channel. A cell holds the cell
//   channel until its final byte is emitted. Unless the byte channel stalls,
//   one byte goes out per cycle and plain cells flow at one per cycle.
// Reset: clears the config registers to zero and empties both stages.
// Stall: a stalled byte holds in the output register; the sequencer stops
//   and the cell channel stalls once the held cell cannot finish.
`timescale 1ns / 1ps

module braille_frame_encoder_unit #(
	parameter int SEQ_MAX = bfe_pkg::SEQ_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bfe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           cell_valid,
	output logic                           cell_stall,
	input  logic [7:0]                     cell_req,
	input  logic                           first_cell,
	input  logic                           last_cell,
	output logic                           byte_valid,
	input  logic                           byte_stall,
	output logic [7:0]                     out_byte,
	output logic                           run_end
);
	import bfe_pkg::*;

	cfg_t     cfg;
	seq_out_t seq_out;
	logic     in_take;
	logic     out_free;
	logic     out_valid_q;
	logic [7:0] out_byte_q;
	logic     run_end_q;

	assign cfg_ready = 1'b1;

	bfe_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bfe_seq #(
		.SEQ_MAX (SEQ_MAX)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (cell_valid),
		.in_cell  (cell_req),
		.in_first (first_cell),
		.in_last  (last_cell),
		.in_take  (in_take),
		.out_free (out_free),
		.seq_out  (seq_out)
	);

	assign cell_stall = !in_take;
	assign out_free   = !out_valid_q || !byte_stall;

	// Output register: load a byte when the slot frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= seq_out.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && seq_out.emit) begin
			out_byte_q <= seq_out.data;
			run_end_q  <= seq_out.last;
		end
	end

	assign byte_valid = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_end    = run_end_q;

	// The sequencer never emits into an occupied output slot
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		seq_out.emit |-> out_free)
		else $error("sequencer emitted while output slot busy");

	// A new cell enters only when the held one has sent its final byte
	a_take_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid && !cell_stall) |-> (!seq_out.busy || (seq_out.emit && seq_out.last)))
		else $error("cell accepted over an unfinished run");

	// A held cell that did not emit stays held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_out.busy && !seq_out.emit) |=> seq_out.busy)
		else $error("held cell lost without emitting");

endmodule
